[hdl/tfas_pkg.sv]
// ----------------------------------------------------------------------------
// tfas_pkg: shared types and constants
// Mode codes and the stage-to-stage request record of the float unit.
// ----------------------------------------------------------------------------
package tfas_pkg;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_I2F = 2'd3
  } mode_t;

  localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
  localparam logic [31:0] MAX_MAG  = 32'h7fff_ffff;
  localparam logic [7:0]  EXP_TOP  = 8'hff;

  // Request record carried from the product-assembly stage to the normalize stage.
  typedef struct packed {
    logic        vld;
    mode_t       mode;
    logic        done;     // result already settled by a special case
    logic [31:0] fixed;    // settled result
    logic        sign;
    logic signed [34:0] exp;  // working exponent
    logic [31:0] man;      // unnormalized mantissa or product
  } stage_t;

endpackage

[hdl/truncating_float_add_sub_mul_unit.sv]
// ----------------------------------------------------------------------------
// truncating_float_add_sub_mul_unit: truncating float add/sub/mul/convert
// Four-stage pipeline over single-precision bit patterns.
// ----------------------------------------------------------------------------
// A request enters when start is high; busy never rises, so one request can
// be issued every cycle. Each result appears on out_result with out_valid
// after the stage 1, 2, 3 and 4 registers, in issue order; the receiver cannot
// stall it. The stages are operand decode and align, partial products and sum,
// product assembly, and normalize and pack.
module truncating_float_add_sub_mul_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  output logic [31:0] out_result
);

  // Stage 1 registers: decoded operands and special-case results.
  logic        v1_r;
  tfas_pkg::mode_t md1_r;
  logic        dn1_r;
  logic [31:0] fx1_r;
  logic        sg1_r;
  logic signed [34:0] e1_r;
  logic [31:0] big1_r, sml1_r;
  logic        neg1_r;
  logic [15:0] ah1_r, al1_r, bh1_r, bl1_r;

  logic        dn1_nxt, sg1_nxt, neg1_nxt;
  logic [31:0] fx1_nxt, big1_nxt, sml1_nxt;
  logic signed [34:0] e1_nxt;
  logic [31:0] a, b, ma7, mb7;
  logic [7:0]  ea, eb, gap;
  logic [23:0] ma, mb;
  logic        a_big;

  assign busy = 1'b0;

  // Operand decode and special cases.
  always_comb begin
    a  = in_operand_a;
    b  = (in_mode == tfas_pkg::MODE_SUB) ? (in_operand_b ^ tfas_pkg::SIGN_BIT)
                                         : in_operand_b;
    ea = a[30:23];
    eb = b[30:23];
    ma = {1'b1, a[22:0]};
    mb = {1'b1, b[22:0]};
    ma7 = {1'b0, ma, 7'd0};
    mb7 = {1'b0, mb, 7'd0};
    a_big = !(ea < eb || (ea == eb && ma < mb));
    gap = a_big ? (ea - eb) : (eb - ea);
    dn1_nxt = 1'b0;
    fx1_nxt = 32'd0;
    sg1_nxt = 1'b0;
    e1_nxt  = 35'sd0;
    big1_nxt = 32'd0;
    sml1_nxt = 32'd0;
    neg1_nxt = 1'b0;
    unique case (tfas_pkg::mode_t'(in_mode))
      tfas_pkg::MODE_ADD, tfas_pkg::MODE_SUB: begin
        sg1_nxt  = a_big ? a[31] : b[31];
        neg1_nxt = a[31] ^ b[31];
        e1_nxt   = 35'(a_big ? ea : eb);
        big1_nxt = {8'd0, a_big ? ma : mb};
        sml1_nxt = {8'd0, a_big ? (mb >> gap) : (ma >> gap)};
        if (ea == 8'd0)      begin dn1_nxt = 1'b1; fx1_nxt = b; end
        else if (eb == 8'd0) begin dn1_nxt = 1'b1; fx1_nxt = a; end
        else if (gap >= 8'd24 || (a_big ? ea : eb) == tfas_pkg::EXP_TOP) begin
          dn1_nxt = 1'b1;
          fx1_nxt = a_big ? a : b;
        end
      end
      tfas_pkg::MODE_MUL: begin
        sg1_nxt = a[31] ^ b[31];
        e1_nxt  = 35'(ea) + 35'(eb) - 35'sd132;
        if (ea == tfas_pkg::EXP_TOP) begin
          dn1_nxt = 1'b1;
          fx1_nxt = (eb == tfas_pkg::EXP_TOP ? tfas_pkg::MAX_MAG : a)
                    | {sg1_nxt, 31'd0};
        end else if (ea == 8'd0 || eb == 8'd0) begin
          dn1_nxt = 1'b1;
          fx1_nxt = {sg1_nxt, 31'd0};
        end else if (eb == tfas_pkg::EXP_TOP) begin
          dn1_nxt = 1'b1;
          fx1_nxt = b | {sg1_nxt, 31'd0};
        end
      end
      default: begin
        e1_nxt   = 35'sd150 - 35'(b);
        big1_nxt = a;
        if (a == 32'd0) begin dn1_nxt = 1'b1; fx1_nxt = 32'd0; end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start;
    md1_r  <= tfas_pkg::mode_t'(in_mode);
    dn1_r  <= dn1_nxt;
    fx1_r  <= fx1_nxt;
    sg1_r  <= sg1_nxt;
    e1_r   <= e1_nxt;
    big1_r <= big1_nxt;
    sml1_r <= sml1_nxt;
    neg1_r <= neg1_nxt;
    ah1_r  <= ma7[31:16];
    al1_r  <= ma7[15:0];
    bh1_r  <= mb7[31:16];
    bl1_r  <= mb7[15:0];
  end

  // Stage 2: partial products and the add/sub sum.
  logic        v2_r;
  tfas_pkg::mode_t md2_r;
  logic        dn2_r, sg2_r;
  logic [31:0] fx2_r, sum2_r, hl2_r, lh2_r, hh2_r;
  logic signed [34:0] e2_r;
  logic [31:0] sum2_nxt;

  always_comb begin
    if (md1_r == tfas_pkg::MODE_I2F) sum2_nxt = big1_r;
    else sum2_nxt = big1_r + (neg1_r ? (~sml1_r + 32'd1) : sml1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    md2_r  <= md1_r;
    dn2_r  <= dn1_r;
    sg2_r  <= sg1_r;
    fx2_r  <= fx1_r;
    e2_r   <= e1_r;
    sum2_r <= sum2_nxt;
    hl2_r  <= {16'd0, ah1_r} * {16'd0, bl1_r};
    lh2_r  <= {16'd0, al1_r} * {16'd0, bh1_r};
    hh2_r  <= {16'd0, ah1_r} * {16'd0, bh1_r};
  end

  // Stage 3: product assembly and the exact-cancel check.
  tfas_pkg::stage_t s3_r, s3_nxt;
  logic [32:0] mid;

  always_comb begin
    mid = 33'(hl2_r) + 33'(lh2_r);
    s3_nxt.vld   = v2_r;
    s3_nxt.mode  = md2_r;
    s3_nxt.done  = dn2_r;
    s3_nxt.fixed = fx2_r;
    s3_nxt.sign  = sg2_r;
    s3_nxt.exp   = e2_r;
    s3_nxt.man   = sum2_r;
    if (md2_r == tfas_pkg::MODE_MUL) begin
      s3_nxt.man = hh2_r + 32'(mid[32:16]);
    end else if (md2_r != tfas_pkg::MODE_I2F && !dn2_r && sum2_r == 32'd0) begin
      s3_nxt.done  = 1'b1;
      s3_nxt.fixed = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s3_r.vld <= 1'b0;
    else        s3_r.vld <= s3_nxt.vld;
    s3_r.mode  <= s3_nxt.mode;
    s3_r.done  <= s3_nxt.done;
    s3_r.fixed <= s3_nxt.fixed;
    s3_r.sign  <= s3_nxt.sign;
    s3_r.exp   <= s3_nxt.exp;
    s3_r.man   <= s3_nxt.man;
  end

  // Stage 4: normalize, range check and pack.
  logic [31:0] res4_nxt, res4_r;
  logic        v4_r;

  tfas_norm u_norm (
    .st  (s3_r),
    .res (res4_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= s3_r.vld;
    res4_r <= res4_nxt;
  end

  assign out_valid  = v4_r;
  assign out_result = res4_r;

  // Checks.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##4 out_valid) else $error("result lost");
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_r.vld == 1'b0) |=> !out_valid) else $error("invented result");
  a_i2f: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_r.vld && s3_r.mode == tfas_pkg::MODE_I2F) |=> !out_result[31])
    else $error("negative conversion");

endmodule

[hdl/tfas_norm.sv]
// ----------------------------------------------------------------------------
// tfas_norm: normalize and pack
// Finds the leading one of the working mantissa and builds the result word.
// ----------------------------------------------------------------------------
module tfas_norm (
  input  tfas_pkg::stage_t st,
  output logic [31:0]      res
);

  logic [5:0]  lz;
  logic [31:0] m;
  logic signed [34:0] e;
  logic signed [34:0] sh;

  // Leading zero count of the mantissa word.
  always_comb begin
    lz = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (st.man[i]) lz = 6'(31 - i);
    end
  end

  // Bring the leading one to bit 23, then apply the mode's range rules.
  always_comb begin
    sh = 35'(signed'({1'b0, lz})) - 35'sd8;
    m  = 32'd0;
    e  = st.exp - sh;
    res = st.fixed;
    if (!st.done) begin
      if (sh < 0) m = st.man >> (-sh);
      else        m = st.man << sh;
      unique case (st.mode)
        tfas_pkg::MODE_ADD, tfas_pkg::MODE_SUB: begin
          // A left shift that would pass an exponent of zero or less gives a signed zero.
          if (sh > 0 && st.exp - sh < -35'sd1 + 35'sd1 && st.exp <= sh - 35'sd1)
            res = {st.sign, 31'd0};
          else
            res = {st.sign, e[7:0], m[22:0]};
        end
        tfas_pkg::MODE_MUL: begin
          if (e <= 0)           res = {st.sign, 31'd0};
          else if (e >= 35'sd255) res = {st.sign, 31'h7fff_ffff};
          else                  res = {st.sign, e[7:0], m[22:0]};
        end
        default: begin
          if (e <= 0)           res = 32'd0;
          else if (e >= 35'sd255) res = tfas_pkg::MAX_MAG;
          else                  res = {1'b0, e[7:0], m[22:0]};
        end
      endcase
    end
  end

endmodule

[tb/truncating_float_add_sub_mul_unit_tb.sv]
// ----------------------------------------------------------------------------
// truncating_float_add_sub_mul_unit_tb: self-checking bench for the float unit
// Drives directed corner requests and random traffic in all four modes, and
// compares every result against an in-bench truncating float calculator.
// ----------------------------------------------------------------------------
module truncating_float_add_sub_mul_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 12;

  typedef struct {
    tfas_pkg::mode_t mode;
    logic [31:0]     a;
    logic [31:0]     b;
  } request_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_mode;
  logic [31:0] in_operand_a;
  logic [31:0] in_operand_b;
  logic        out_valid;
  logic [31:0] out_result;

  request_t    pending_q[$];
  logic [31:0] expected_q[$];
  int          error_count;
  int          idle_cycles;
  bit          hold_sender;
  int          gap_left;

  truncating_float_add_sub_mul_unit u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (out_valid),
    .out_result   (out_result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Truncating add of two float patterns.
  function automatic logic [31:0] float_add(logic [31:0] a, logic [31:0] b);
    logic [31:0] ea, eb, ma, mb, big, sml, bsign, ssign, sum, gap;
    int e;
    ea = (a >> 23) & 32'hff;
    eb = (b >> 23) & 32'hff;
    if (ea == 0) return b;
    if (eb == 0) return a;
    ma = (a & 32'h7fffff) | 32'h800000;
    mb = (b & 32'h7fffff) | 32'h800000;
    if (ea < eb || (ea == eb && ma < mb)) begin
      gap = eb - ea;
      if (gap >= 24 || eb == 255) return b;
      e = eb; bsign = b & tfas_pkg::SIGN_BIT; ssign = a & tfas_pkg::SIGN_BIT;
      big = mb; sml = ma >> gap;
    end else begin
      gap = ea - eb;
      if (gap >= 24 || ea == 255) return a;
      e = ea; bsign = a & tfas_pkg::SIGN_BIT; ssign = b & tfas_pkg::SIGN_BIT;
      big = ma; sml = mb >> gap;
    end
    if (bsign != ssign) sml = ~sml + 32'd1;
    sum = big + sml;
    if (sum == 0) return 32'd0;
    if ((sum & 32'hff800000) != 0) begin
      while ((sum & 32'hff000000) != 0) begin
        sum = sum >> 1;
        e++;
      end
    end else begin
      while ((sum & 32'h800000) == 0) begin
        if (e <= 0) return bsign;
        sum = sum << 1;
        e--;
      end
    end
    return bsign | ((32'(e) & 32'hff) << 23) | (sum & 32'h7fffff);
  endfunction

  // Truncating multiply with the low partial product dropped.
  function automatic logic [31:0] float_mul(logic [31:0] a, logic [31:0] b);
    logic [31:0] ea, eb, s, ma, mb, p;
    int e;
    ea = (a >> 23) & 32'hff;
    eb = (b >> 23) & 32'hff;
    s  = (a ^ b) & tfas_pkg::SIGN_BIT;
    if (ea == 255) return (eb == 255 ? tfas_pkg::MAX_MAG : a) | s;
    if (ea == 0 || eb == 0) return s;
    if (eb == 255) return b | s;
    e  = int'(ea) + int'(eb) - 'h84;
    ma = ((a & 32'h7fffff) | 32'h800000) << 7;
    mb = ((b & 32'h7fffff) | 32'h800000) << 7;
    p  = (ma >> 16) * (mb & 32'hffff) + (ma & 32'hffff) * (mb >> 16);
    p  = p >> 16;
    p  = p + (ma >> 16) * (mb >> 16);
    while ((p & 32'hff000000) != 0) begin
      p = p >> 1;
      e++;
    end
    if (e <= 0) return s;
    if (e >= 255) return tfas_pkg::MAX_MAG | s;
    return s | (32'(e) << 23) | (p & 32'h7fffff);
  endfunction

  // Unsigned integer to float, scaled down by a power of two.
  function automatic logic [31:0] int_to_float(logic [31:0] a, logic [31:0] b);
    longint e;
    e = 'h96;
    if (a == 0) return 32'd0;
    while ((a & 32'hff000000) != 0) begin
      a = a >> 1;
      e++;
    end
    while ((a & 32'h800000) == 0) begin
      a = a << 1;
      e--;
    end
    e = e - longint'(b);
    if (e <= 0) return 32'd0;
    if (e >= 255) return tfas_pkg::MAX_MAG;
    return (32'(e) << 23) | (a & 32'h7fffff);
  endfunction

  function automatic logic [31:0] float_unit_result(request_t r);
    case (r.mode)
      tfas_pkg::MODE_ADD: return float_add(r.a, r.b);
      tfas_pkg::MODE_SUB: return float_add(r.a, r.b ^ tfas_pkg::SIGN_BIT);
      tfas_pkg::MODE_MUL: return float_mul(r.a, r.b);
      default:            return int_to_float(r.a, r.b);
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic push_request(tfas_pkg::mode_t m, logic [31:0] a, logic [31:0] b);
    request_t r;
    r.mode = m;
    r.a = a;
    r.b = b;
    pending_q.push_back(r);
  endtask

  // Float pattern biased toward interesting exponents.
  function automatic logic [31:0] rand_float();
    logic [7:0] ex;
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) ex = 8'd0;
    else if (sel == 1) ex = 8'hff;
    else if (sel < 4) ex = 8'($urandom_range(0, 3));
    else if (sel < 6) ex = 8'($urandom_range(252, 255));
    else ex = 8'($urandom_range(100, 154));
    return {1'($urandom), ex, 23'($urandom)};
  endfunction

  // Driver: issue requests at the falling edge, with random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) void'(pending_q.pop_front());
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (hold_sender || pending_q.size() == 0) begin
        start <= 1'b0;
      end else begin
        start        <= 1'b1;
        in_mode      <= pending_q[0].mode;
        in_operand_a <= pending_q[0].a;
        in_operand_b <= pending_q[0].b;
        case ($urandom_range(0, 19))
          0, 1, 2: gap_left <= $urandom_range(1, 3);
          3:       gap_left <= $urandom_range(8, 40);
          default: gap_left <= 0;
        endcase
      end
    end
  end

  // Monitor: predict on acceptance, check each strobed result.
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n) begin
      if (start && !busy) begin
        request_t r;
        r.mode = tfas_pkg::mode_t'(in_mode);
        r.a = in_operand_a;
        r.b = in_operand_b;
        expected_q.push_back(float_unit_result(r));
      end
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_result));
        end else begin
          want = expected_q.pop_front();
          if (out_result !== want)
            report_mismatch($sformatf("result %h, expected %h", out_result, want));
        end
      end
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int n;
    tfas_pkg::mode_t m;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_mode      = tfas_pkg::MODE_ADD;
    in_operand_a = '0;
    in_operand_b = '0;
    error_count  = 0;
    idle_cycles  = 0;
    hold_sender  = 1'b1;
    gap_left     = 0;

    // Directed corners: zeros, top exponents, cancellation, carry, underflow.
    push_request(tfas_pkg::MODE_ADD, 32'h0000_0000, 32'hc040_0000);
    push_request(tfas_pkg::MODE_ADD, 32'h3f80_0000, 32'h007f_ffff);
    push_request(tfas_pkg::MODE_ADD, 32'h4b80_0000, 32'h3f80_0000);
    push_request(tfas_pkg::MODE_ADD, 32'h7f80_0001, 32'h3f80_0000);
    push_request(tfas_pkg::MODE_ADD, 32'h3fc0_0000, 32'hbfc0_0000);
    push_request(tfas_pkg::MODE_ADD, 32'h7f7f_ffff, 32'h7f7f_ffff);
    push_request(tfas_pkg::MODE_ADD, 32'h0080_0001, 32'h8080_0000);
    push_request(tfas_pkg::MODE_ADD, 32'h0100_0000, 32'h80ff_ffff);
    push_request(tfas_pkg::MODE_SUB, 32'h3f80_0000, 32'h3f80_0000);
    push_request(tfas_pkg::MODE_SUB, 32'hffff_ffff, 32'h7fff_ffff);
    push_request(tfas_pkg::MODE_SUB, 32'h4000_0000, 32'h3f7f_ffff);
    push_request(tfas_pkg::MODE_MUL, 32'h7f80_0000, 32'hff80_0000);
    push_request(tfas_pkg::MODE_MUL, 32'hff80_1234, 32'h3f80_0000);
    push_request(tfas_pkg::MODE_MUL, 32'h3f80_0000, 32'h8000_0001);
    push_request(tfas_pkg::MODE_MUL, 32'h3f80_0000, 32'hff80_0005);
    push_request(tfas_pkg::MODE_MUL, 32'h7f00_0000, 32'h4000_0000);
    push_request(tfas_pkg::MODE_MUL, 32'h0080_0000, 32'h0080_0000);
    push_request(tfas_pkg::MODE_MUL, 32'h3fff_ffff, 32'hbfff_ffff);
    push_request(tfas_pkg::MODE_I2F, 32'h0000_0000, 32'h0000_0005);
    push_request(tfas_pkg::MODE_I2F, 32'hffff_ffff, 32'h0000_0000);
    push_request(tfas_pkg::MODE_I2F, 32'h0000_0001, 32'h0000_0096);
    push_request(tfas_pkg::MODE_I2F, 32'h0000_0001, 32'hffff_ff00);
    push_request(tfas_pkg::MODE_I2F, 32'h0000_0001, 32'hffff_ffff);
    push_request(tfas_pkg::MODE_I2F, 32'h1234_5678, 32'h8000_0000);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    hold_sender = 1'b0;

    // Random traffic; halfway, let the pipeline drain fully once.
    for (int i = 0; i < 1750; i++) begin
      m = tfas_pkg::mode_t'($urandom_range(0, 3));
      if (m == tfas_pkg::MODE_I2F) begin
        n = $urandom_range(0, 9);
        push_request(m, n < 2 ? 32'($urandom_range(0, 300)) : 32'($urandom),
                     n < 7 ? 32'($urandom_range(0, 200)) : 32'($urandom));
      end else if ($urandom_range(0, 3) == 0) begin
        logic [31:0] x;
        x = rand_float();
        push_request(m, x, {1'($urandom), x[30:23] - 8'($urandom_range(0, 2)),
                            23'($urandom)});
      end else begin
        push_request(m, rand_float(), rand_float());
      end
      if (i == 875) begin
        while (pending_q.size() > 0) @(posedge clk);
        @(negedge clk);
        hold_sender = 1'b1;
        while (expected_q.size() > 0) @(posedge clk);
        @(negedge clk);
        hold_sender = 1'b0;
      end
    end
    while (pending_q.size() > 0 || start) @(posedge clk);
    while (expected_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hdl/tfas_pkg.sv
hdl/tfas_norm.sv
hdl/truncating_float_add_sub_mul_unit.sv
tb/truncating_float_add_sub_mul_unit_tb.sv
